>>> hdl/assert_macros.svh
// assertion macros shared by the rotation address generator
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define RNAG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define RNAG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/rnag_pkg.sv
// shared types and constants of the rotation address generator
// no dependencies
`default_nettype none

package rnag_pkg;

	// field widths of the words and registers
	localparam int unsigned COORD_W   = 13;
	localparam int unsigned SRC_W     = 12;
	localparam int unsigned BOX_W     = 13;
	localparam int unsigned TRIG_W    = 16;
	localparam int unsigned DIMREG_W  = 13;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// default parameter values
	localparam int unsigned MAX_DIM_DEF   = 4096;
	localparam int unsigned FRAC_BITS_DEF = 14;

	// saturation value of the box size
	localparam logic [BOX_W-1:0] BOX_SAT = 13'd8191;

	// register reset values
	localparam logic signed [TRIG_W-1:0] COS_RST  = 16'sd16384;
	localparam logic signed [TRIG_W-1:0] SIN_RST  = 16'sd0;
	localparam logic [DIMREG_W-1:0]      ROWS_RST = 13'd512;
	localparam logic [DIMREG_W-1:0]      COLS_RST = 13'd512;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COS  = 2'd0,
		REG_SIN  = 2'd1,
		REG_ROWS = 2'd2,
		REG_COLS = 2'd3
	} reg_idx_t;

endpackage

`default_nettype wire

>>> hdl/rnag_in_if.sv
// input channel: one output pixel coordinate per word
// depends on rnag_pkg
`default_nettype none

interface rnag_in_if;
	logic                              valid;
	logic                              ready;
	logic [rnag_pkg::COORD_W-1:0]      out_row;
	logic [rnag_pkg::COORD_W-1:0]      out_col;

	modport source (output valid, output out_row, output out_col, input ready);
	modport sink (input valid, input out_row, input out_col, output ready);
endinterface

`default_nettype wire

>>> hdl/rnag_out_if.sv
// output channel: source address, inside flag and box size per word
// depends on rnag_pkg
`default_nettype none

interface rnag_out_if;
	logic                         valid;
	logic                         ready;
	logic [rnag_pkg::SRC_W-1:0]   src_row;
	logic [rnag_pkg::SRC_W-1:0]   src_col;
	logic                         inside_res;
	logic [rnag_pkg::BOX_W-1:0]   box_rows;
	logic [rnag_pkg::BOX_W-1:0]   box_cols;

	modport source (output valid, output src_row, output src_col, output inside_res,
		output box_rows, output box_cols, input ready);
	modport sink (input valid, input src_row, input src_col, input inside_res,
		input box_rows, input box_cols, output ready);
endinterface

`default_nettype wire

>>> hdl/rotate_nearest_address_gen.sv
// Nearest-neighbor rotation address generator. Every word on req carries one output
// pixel coordinate; the matching word on rsp gives the source pixel to copy, a flag
// that it lies inside the source image, and the rotated box size. One word is
// accepted per clock unless rsp stalls; the multiplier stage forms all four
// back-rotation products of a word in parallel. When rsp is not taken the whole
// pipeline holds and req.ready drops. The box corners are worked out from the
// registers in a separate four-stage chain, so a word sent right after a register
// write already sees the new angle and size.
// depends on rnag_pkg, rnag_in_if, rnag_out_if and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module rotate_nearest_address_gen #(
	parameter int unsigned MAX_DIM   = rnag_pkg::MAX_DIM_DEF,
	parameter int unsigned FRAC_BITS = rnag_pkg::FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [rnag_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [rnag_pkg::CFG_W-1:0]        cfg_wdata,
	rnag_in_if.sink                                req,
	rnag_out_if.source                             rsp
);

	localparam int unsigned TW     = rnag_pkg::TRIG_W;
	localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
	localparam int unsigned PRD_W  = DIM_W + 1 + TW;
	localparam int unsigned XW     = PRD_W + 1;
	localparam int unsigned SH_W   = rnag_pkg::COORD_W + 1 + FRAC_BITS;
	localparam int unsigned PQ_W   = ((SH_W > XW) ? SH_W : XW) + 1;
	localparam int unsigned PM_W   = PQ_W + TW;
	localparam int unsigned V_W    = PM_W + 1;
	localparam int unsigned RI_W   = V_W + 1 - 2 * FRAC_BITS;
	localparam int unsigned CMP_W  = (RI_W > DIM_W + 1) ? RI_W : DIM_W + 1;
	localparam int unsigned BQ_W   = XW + 2 - FRAC_BITS;
	localparam int unsigned IM_W   = rnag_pkg::COORD_W + 1;

	localparam logic signed [V_W:0] RND2 = {{(V_W + 1 - 2 * FRAC_BITS){1'b0}},
		{(2 * FRAC_BITS){1'b1}}};
	localparam logic [XW+1:0] RND1 = {{(XW + 2 - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

	// configuration registers
	logic signed [TW-1:0]                  cos_q;
	logic signed [TW-1:0]                  sin_q;
	logic [rnag_pkg::DIMREG_W-1:0]         rows_q;
	logic [rnag_pkg::DIMREG_W-1:0]         cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q  <= rnag_pkg::COS_RST;
			sin_q  <= rnag_pkg::SIN_RST;
			rows_q <= rnag_pkg::ROWS_RST;
			cols_q <= rnag_pkg::COLS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				rnag_pkg::REG_COS:  cos_q  <= cfg_wdata[TW-1:0];
				rnag_pkg::REG_SIN:  sin_q  <= cfg_wdata[TW-1:0];
				rnag_pkg::REG_ROWS: rows_q <= cfg_wdata[rnag_pkg::DIMREG_W-1:0];
				rnag_pkg::REG_COLS: cols_q <= cfg_wdata[rnag_pkg::DIMREG_W-1:0];
			endcase
		end
	end

	// dimensions clamped to the supported maximum
	logic [DIM_W-1:0] rows_eff;
	logic [DIM_W-1:0] cols_eff;

	assign rows_eff = ({2'b0, rows_q} > 15'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(rows_q);
	assign cols_eff = ({2'b0, cols_q} > 15'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(cols_q);

	// ---------------- corner chain, free running off the registers ----------------

	// corner products
	logic signed [PRD_W-1:0] rc_s1, rs_s1, cc_s1, cs_s1;

	always_ff @(posedge clk) begin
		rc_s1 <= $signed({1'b0, rows_eff}) * cos_q;
		rs_s1 <= $signed({1'b0, rows_eff}) * sin_q;
		cc_s1 <= $signed({1'b0, cols_eff}) * cos_q;
		cs_s1 <= $signed({1'b0, cols_eff}) * sin_q;
	end

	// rotated corners (1,1) (1,C) (R,1) (R,C)
	logic signed [XW-1:0] xs_s2 [4];
	logic signed [XW-1:0] ys_s2 [4];

	always_ff @(posedge clk) begin
		xs_s2[0] <= XW'(cos_q) + XW'(sin_q);
		xs_s2[1] <= XW'(cos_q) + XW'(cs_s1);
		xs_s2[2] <= XW'(rc_s1) + XW'(sin_q);
		xs_s2[3] <= XW'(rc_s1) + XW'(cs_s1);
		ys_s2[0] <= XW'(cos_q) - XW'(sin_q);
		ys_s2[1] <= XW'(cc_s1) - XW'(sin_q);
		ys_s2[2] <= XW'(cos_q) - XW'(rs_s1);
		ys_s2[3] <= XW'(cc_s1) - XW'(rs_s1);
	end

	// extremes of the corners, two compare levels
	logic signed [XW-1:0] minx_c, maxx_c, miny_c, maxy_c;
	logic signed [XW-1:0] mnx_a, mnx_b, mxx_a, mxx_b, mny_a, mny_b, mxy_a, mxy_b;
	logic signed [XW-1:0] minx_s3, maxx_s3, miny_s3, maxy_s3;

	always_comb begin
		mnx_a  = (xs_s2[1] < xs_s2[0]) ? xs_s2[1] : xs_s2[0];
		mnx_b  = (xs_s2[3] < xs_s2[2]) ? xs_s2[3] : xs_s2[2];
		mxx_a  = (xs_s2[1] > xs_s2[0]) ? xs_s2[1] : xs_s2[0];
		mxx_b  = (xs_s2[3] > xs_s2[2]) ? xs_s2[3] : xs_s2[2];
		mny_a  = (ys_s2[1] < ys_s2[0]) ? ys_s2[1] : ys_s2[0];
		mny_b  = (ys_s2[3] < ys_s2[2]) ? ys_s2[3] : ys_s2[2];
		mxy_a  = (ys_s2[1] > ys_s2[0]) ? ys_s2[1] : ys_s2[0];
		mxy_b  = (ys_s2[3] > ys_s2[2]) ? ys_s2[3] : ys_s2[2];
		minx_c = (mnx_b < mnx_a) ? mnx_b : mnx_a;
		maxx_c = (mxx_b > mxx_a) ? mxx_b : mxx_a;
		miny_c = (mny_b < mny_a) ? mny_b : mny_a;
		maxy_c = (mxy_b > mxy_a) ? mxy_b : mxy_a;
	end

	always_ff @(posedge clk) begin
		minx_s3 <= minx_c;
		maxx_s3 <= maxx_c;
		miny_s3 <= miny_c;
		maxy_s3 <= maxy_c;
	end

	// box size: ceiling of the extent, saturated
	logic [XW:0]                 extx, exty;
	logic [XW+1:0]               upx, upy;
	logic [BQ_W-1:0]             bqx, bqy;
	logic [rnag_pkg::BOX_W-1:0]  box_rows_s4, box_cols_s4;

	always_comb begin
		extx = (XW+1)'(maxx_s3) - (XW+1)'(minx_s3);
		exty = (XW+1)'(maxy_s3) - (XW+1)'(miny_s3);
		upx  = {1'b0, extx} + RND1;
		upy  = {1'b0, exty} + RND1;
		bqx  = upx[XW+1:FRAC_BITS];
		bqy  = upy[XW+1:FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		box_rows_s4 <= (bqx > BQ_W'(rnag_pkg::BOX_SAT)) ? rnag_pkg::BOX_SAT
			: rnag_pkg::BOX_W'(bqx);
		box_cols_s4 <= (bqy > BQ_W'(rnag_pkg::BOX_SAT)) ? rnag_pkg::BOX_SAT
			: rnag_pkg::BOX_W'(bqy);
	end

	// ---------------- word pipeline ----------------

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// the whole pipeline moves when the output register is empty or its word is being taken
	assign adv       = !v_s7 || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// coordinates less one, delayed until the box minimum is ready
	logic signed [IM_W-1:0] im1_s1, im1_s2, im1_s3;
	logic signed [IM_W-1:0] jm1_s1, jm1_s2, jm1_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			im1_s1 <= $signed({1'b0, req.out_row}) - IM_W'(1);
			jm1_s1 <= $signed({1'b0, req.out_col}) - IM_W'(1);
			im1_s2 <= im1_s1;
			jm1_s2 <= jm1_s1;
			im1_s3 <= im1_s2;
			jm1_s3 <= jm1_s2;
		end
	end

	// offset into the rotated frame
	logic signed [PQ_W-1:0] p_s4, q_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s4 <= PQ_W'($signed({im1_s3, {FRAC_BITS{1'b0}}})) + PQ_W'(minx_s3);
			q_s4 <= PQ_W'($signed({jm1_s3, {FRAC_BITS{1'b0}}})) + PQ_W'(miny_s3);
		end
	end

	// back-rotation products
	logic signed [PM_W-1:0] pc_s5, qs_s5, ps_s5, qc_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			pc_s5 <= p_s4 * cos_q;
			qs_s5 <= q_s4 * sin_q;
			ps_s5 <= p_s4 * sin_q;
			qc_s5 <= q_s4 * cos_q;
		end
	end

	// sums and ceiling to whole pixels
	logic signed [V_W:0]    vr_up, vc_up;
	logic signed [RI_W-1:0] ri_s6, rj_s6;

	always_comb begin
		vr_up = (V_W+1)'(pc_s5) - (V_W+1)'(qs_s5) + RND2;
		vc_up = (V_W+1)'(ps_s5) + (V_W+1)'(qc_s5) + RND2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ri_s6 <= RI_W'(vr_up >>> (2 * FRAC_BITS));
			rj_s6 <= RI_W'(vc_up >>> (2 * FRAC_BITS));
		end
	end

	// bounds check and output register
	logic signed [CMP_W-1:0]    ri_x, rj_x, rlim, clim;
	logic                       inside_c;
	logic [rnag_pkg::SRC_W-1:0] src_row_s7, src_col_s7;
	logic                       inside_s7;
	logic [rnag_pkg::BOX_W-1:0] box_rows_s7, box_cols_s7;

	always_comb begin
		ri_x     = CMP_W'(ri_s6);
		rj_x     = CMP_W'(rj_s6);
		rlim     = CMP_W'($signed({1'b0, rows_eff}));
		clim     = CMP_W'($signed({1'b0, cols_eff}));
		inside_c = !ri_x[CMP_W-1] && !rj_x[CMP_W-1] && (ri_x < rlim) && (rj_x < clim);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src_row_s7  <= inside_c ? rnag_pkg::SRC_W'(ri_x) : '0;
			src_col_s7  <= inside_c ? rnag_pkg::SRC_W'(rj_x) : '0;
			inside_s7   <= inside_c;
			box_rows_s7 <= box_rows_s4;
			box_cols_s7 <= box_cols_s4;
		end
	end

	assign rsp.valid      = v_s7;
	assign rsp.src_row    = src_row_s7;
	assign rsp.src_col    = src_col_s7;
	assign rsp.inside_res = inside_s7;
	assign rsp.box_rows   = box_rows_s7;
	assign rsp.box_cols   = box_cols_s7;

	// ---------------- assertions ----------------

	`RNAG_ASSERT(a_inside_in_range,
		!(rsp.valid && rsp.inside_res)
			|| ((rsp.src_row < rows_eff) && (rsp.src_col < cols_eff)),
		"inside word addresses a pixel beyond the source")
	`RNAG_ASSERT(a_outside_zero,
		!(rsp.valid && !rsp.inside_res)
			|| ((rsp.src_row == '0) && (rsp.src_col == '0)),
		"outside word carries a nonzero address")
	`RNAG_ASSERT_NEXT(a_stall_holds, v_s6 && !adv,
		v_s6 && $stable(ri_s6) && $stable(rj_s6),
		"stalled stage lost its word")

endmodule

`default_nettype wire

>>> bench/tb_rotate_nearest_address_gen.sv
`timescale 1ns / 100ps
// self-checking bench for rotate_nearest_address_gen: predicts each source address and box size
// depends on rnag_pkg, rnag_in_if, rnag_out_if and the block itself

module tb_rotate_nearest_address_gen;
	import rnag_pkg::*;

	localparam int     FRAC        = FRAC_BITS_DEF;
	localparam int     CYCLE_LIMIT = 400000;
	localparam int     LONG_HOLD   = 60;
	localparam real    PI          = 3.14159265358979;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} pixel_t;

	typedef struct packed {
		logic [SRC_W-1:0] row;
		logic [SRC_W-1:0] col;
		logic             in_src;
		logic [BOX_W-1:0] box_rows;
		logic [BOX_W-1:0] box_cols;
	} src_addr_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	rnag_in_if  req_if ();
	rnag_out_if rsp_if ();

	rotate_nearest_address_gen uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	// shadow copy of the angle and size registers
	logic signed [TRIG_W-1:0] cos_sh  = COS_RST;
	logic signed [TRIG_W-1:0] sin_sh  = SIN_RST;
	logic [DIMREG_W-1:0]      rows_sh = ROWS_RST;
	logic [DIMREG_W-1:0]      cols_sh = COLS_RST;

	pixel_t    pixel_q[$];
	src_addr_t src_addr_q[$];
	src_addr_t got_addr;
	src_addr_t want_addr;
	int        pixels_queued  = 0;
	int        pixels_taken   = 0;
	int        mismatches     = 0;
	int        cycles         = 0;
	int        send_gap       = 0;
	int        recv_stall     = 0;
	logic      word_taken     = 1'b0;
	bit        calm           = 1'b0;
	bit        long_hold_done = 1'b0;

	// ceiling of v / 2^sh, exact for either sign
	function automatic longint ceil_shr(input longint v, input int sh);
		longint m;
		m = longint'(1) << sh;
		if (v >= 0)
			return (v + m - 1) / m;
		return v / m;
	endfunction

	function automatic logic [BOX_W-1:0] box_size(input longint extent);
		longint b;
		b = ceil_shr(extent, FRAC);
		if (b < 0)
			b = 0;
		if (b > BOX_SAT)
			b = BOX_SAT;
		return b[BOX_W-1:0];
	endfunction

	// inverse mapping of one output pixel to its source pixel
	function automatic src_addr_t map_pixel(input pixel_t px);
		longint    c, s, nr, nc, cr, cc, x, y;
		longint    minx, maxx, miny, maxy, p, q, ri, rj;
		int        k;
		src_addr_t a;
		c  = cos_sh;
		s  = sin_sh;
		nr = (rows_sh > MAX_DIM_DEF) ? MAX_DIM_DEF : rows_sh;
		nc = (cols_sh > MAX_DIM_DEF) ? MAX_DIM_DEF : cols_sh;
		// bounding box of the four rotated corners
		for (k = 0; k < 4; k++) begin
			cr = (k < 2) ? 1 : nr;
			cc = (k % 2 == 0) ? 1 : nc;
			x  = cr * c + cc * s;
			y  = cc * c - cr * s;
			if (k == 0) begin
				minx = x;
				maxx = x;
				miny = y;
				maxy = y;
			end else begin
				if (x < minx) minx = x;
				if (x > maxx) maxx = x;
				if (y < miny) miny = y;
				if (y > maxy) maxy = y;
			end
		end
		// offset into the box, then rotate back with the transpose
		p  = (longint'(px.row) - 1) * (longint'(1) << FRAC) + minx;
		q  = (longint'(px.col) - 1) * (longint'(1) << FRAC) + miny;
		ri = ceil_shr(p * c - q * s, 2 * FRAC);
		rj = ceil_shr(p * s + q * c, 2 * FRAC);
		a.in_src   = (ri >= 0) && (rj >= 0) && (ri < nr) && (rj < nc);
		a.row      = a.in_src ? ri[SRC_W-1:0] : '0;
		a.col      = a.in_src ? rj[SRC_W-1:0] : '0;
		a.box_rows = box_size(maxx - minx);
		a.box_cols = box_size(maxy - miny);
		return a;
	endfunction

	function automatic logic signed [TRIG_W-1:0] to_trig(input real v);
		int q;
		q = $rtoi(v * (1 << FRAC) + ((v < 0.0) ? -0.5 : 0.5));
		return q[TRIG_W-1:0];
	endfunction

	// mostly small sizes, sometimes large, zero or oversized
	function automatic logic [DIMREG_W-1:0] rand_dim();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return DIMREG_W'($urandom_range(MAX_DIM_DEF + 1, 8191));
		if (sel == 1)
			return '0;
		if (sel <= 4)
			return DIMREG_W'($urandom_range(49, MAX_DIM_DEF));
		return DIMREG_W'($urandom_range(1, 48));
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_COS:  cos_sh  = val;
			REG_SIN:  sin_sh  = val;
			REG_ROWS: rows_sh = val[DIMREG_W-1:0];
			REG_COLS: cols_sh = val[DIMREG_W-1:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(input logic signed [TRIG_W-1:0] c, input logic signed [TRIG_W-1:0] s,
		input logic [DIMREG_W-1:0] r, input logic [DIMREG_W-1:0] k);
		write_reg(REG_COS, c);
		write_reg(REG_SIN, s);
		write_reg(REG_ROWS, CFG_W'(r));
		write_reg(REG_COLS, CFG_W'(k));
		@(posedge clk);
	endtask

	task automatic queue_pixel(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
		pixel_q.push_back({r, c});
		pixels_queued++;
	endtask

	// wait until every queued word is taken and answered
	task automatic drain();
		while (pixels_taken != pixels_queued || src_addr_q.size() != 0)
			@(negedge clk);
	endtask

	// random angle and size, then words mostly inside the box
	task automatic random_phase(input int n_items, input bit split);
		int                       mode, deg, i, lim_r, lim_c;
		real                      th;
		logic signed [TRIG_W-1:0] c, s;
		src_addr_t                box;
		mode = $urandom_range(0, 3);
		case (mode)
			0, 1: begin
				deg = $urandom_range(0, 359);
				th  = deg * PI / 180.0;
				c   = to_trig($cos(th));
				s   = to_trig($sin(th));
			end
			2: begin
				c = TRIG_W'(int'($urandom_range(0, 32768)) - 16384);
				s = TRIG_W'(int'($urandom_range(0, 32768)) - 16384);
			end
			default: begin
				c = TRIG_W'((int'($urandom_range(0, 2)) - 1) * 16384);
				s = TRIG_W'((int'($urandom_range(0, 2)) - 1) * 16384);
			end
		endcase
		set_regs(c, s, rand_dim(), rand_dim());
		box   = map_pixel('0);
		lim_r = (box.box_rows >= 8190) ? 8191 : box.box_rows + 1;
		lim_c = (box.box_cols >= 8190) ? 8191 : box.box_cols + 1;
		for (i = 0; i < n_items; i++) begin
			// sender holds back until the block is empty
			if (split && i == n_items / 2) begin
				drain();
				@(posedge clk);
			end
			if ($urandom_range(0, 3) == 0)
				queue_pixel(COORD_W'($urandom_range(0, 8191)),
					COORD_W'($urandom_range(0, 8191)));
			else
				queue_pixel(COORD_W'($urandom_range(0, lim_r)),
					COORD_W'($urandom_range(0, lim_c)));
		end
		drain();
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// request side: one word per slot, random gaps after a word
	always @(negedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || word_taken) begin
			if (send_gap > 0) begin
				req_if.valid <= 1'b0;
				send_gap--;
			end else if (pixel_q.size() > 0) begin
				{req_if.out_row, req_if.out_col} <= pixel_q.pop_front();
				req_if.valid <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(1, 7);
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// response side: random stall bursts and one long hold
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (recv_stall > 0) begin
			rsp_if.ready <= 1'b0;
			recv_stall--;
		end else if (!long_hold_done && pixels_taken >= 400) begin
			long_hold_done = 1'b1;
			recv_stall = LONG_HOLD - 1;
			rsp_if.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			recv_stall = $urandom_range(0, 6);
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	// accepted words feed the prediction, result words are checked in order
	always @(posedge clk) begin
		cycles++;
		word_taken <= arst_n && req_if.valid && req_if.ready;
		if (arst_n && req_if.valid && req_if.ready) begin
			src_addr_q.push_back(map_pixel({req_if.out_row, req_if.out_col}));
			pixels_taken++;
		end
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got_addr = {rsp_if.src_row, rsp_if.src_col, rsp_if.inside_res,
				rsp_if.box_rows, rsp_if.box_cols};
			if (src_addr_q.size() == 0) begin
				$display("%0t: unexpected word: expected none, got row %0d col %0d inside %0d",
					$time, got_addr.row, got_addr.col, got_addr.in_src);
				mismatches++;
			end else begin
				want_addr = src_addr_q.pop_front();
				check_field("src_row", want_addr.row, got_addr.row);
				check_field("src_col", want_addr.col, got_addr.col);
				check_field("inside_res", want_addr.in_src, got_addr.in_src);
				check_field("box_rows", want_addr.box_rows, got_addr.box_rows);
				check_field("box_cols", want_addr.box_cols, got_addr.box_cols);
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// reset, directed phases, random phases, quiet tail
	initial begin
		int n;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_idx        = REG_COS;
		cfg_wdata      = '0;
		req_if.valid   = 1'b0;
		req_if.out_row = '0;
		req_if.out_col = '0;
		rsp_if.ready   = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// reset angle and size: identity mapping, edges of the source
		@(posedge clk);
		queue_pixel(1, 1);
		queue_pixel(0, 0);
		queue_pixel(8191, 8191);
		queue_pixel(512, 512);
		queue_pixel(1, 512);
		queue_pixel(513, 1);
		drain();

		// zero rows with oversized columns
		set_regs(-16384, 16384, 0, 8191);
		queue_pixel(0, 0);
		queue_pixel(1, 1);
		queue_pixel(4096, 2);
		queue_pixel(8191, 0);
		drain();

		// quarter turn, largest rows, single column
		set_regs(0, -16384, MAX_DIM_DEF, 1);
		queue_pixel(1, 1);
		queue_pixel(4096, 1);
		queue_pixel(2, 4096);
		queue_pixel(8191, 8191);
		drain();

		// cosine and sine that are not a rotation, oversized rows, zero columns
		set_regs(16384, 16384, 8191, 0);
		queue_pixel(1, 1);
		queue_pixel(100, 100);
		queue_pixel(0, 8191);
		queue_pixel(8191, 0);
		drain();

		// degenerate angle, single pixel source
		set_regs(0, 0, 1, 1);
		queue_pixel(1, 1);
		queue_pixel(5, 5);
		drain();

		for (n = 0; n < 15; n++)
			random_phase(120, n == 3);

		// no idling on either side at the end
		calm = 1'b1;
		random_phase(80, 1'b0);

		repeat (16) @(posedge clk);
		if (mismatches == 0 && src_addr_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
